// ===== src/nsd_pkg.sv =====
// Shared types and constants for the wrapped nearest-seed distance unit.
// No dependencies; imported by nsd_dist and the top level (nsd_ram does not use it).
package nsd_pkg;

    // field widths fixed by the interface
    localparam int OP_W     = 1;
    localparam int SIDX_W   = 5;
    localparam int XY_W     = 10;
    localparam int PIX_W    = 7;
    localparam int CFG_W    = 6;
    localparam int DIST_W   = 20;
    localparam int NIDX_W   = 5;
    localparam int MAG_W    = 10;

    // parameter defaults
    localparam int GRID_WIDTH_DEF  = 128;
    localparam int GRID_HEIGHT_DEF = 128;
    localparam int MAX_SEEDS_DEF   = 32;

    // search start value and register reset value
    localparam logic [DIST_W-1:0] START_MIN  = DIST_W'(1000000);
    localparam logic [CFG_W-1:0]  ACTIVE_RST = CFG_W'(1);

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    // query sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ===== src/nsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nsd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nsd_dist.sv =====
// Three-stage wrapped squared-distance pipeline: fold per axis, square, sum.
// Depends on nsd_pkg for field widths.
module nsd_dist
    import nsd_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int AW          = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [AW-1:0]     i_idx,
    input  logic [XY_W-1:0]   i_seed_x,
    input  logic [XY_W-1:0]   i_seed_y,
    input  logic [PIX_W-1:0]  i_px,
    input  logic [PIX_W-1:0]  i_py,
    output logic              o_valid,
    output logic [AW-1:0]     o_idx,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_busy
);

    localparam logic signed [11:0] GRID_X = 12'(GRID_WIDTH);
    localparam logic signed [11:0] GRID_Y = 12'(GRID_HEIGHT);
    localparam logic signed [11:0] HALF_X = 12'(GRID_WIDTH / 2);
    localparam logic signed [11:0] HALF_Y = 12'(GRID_HEIGHT / 2);

    // |p - s|, folded once by the grid size, then magnitude of the result
    function automatic logic [MAG_W-1:0] fold_mag(
        input logic [PIX_W-1:0] p,
        input logic [XY_W-1:0]  s,
        input logic signed [11:0] grid,
        input logic signed [11:0] half
    );
        logic signed [11:0] d;
        logic signed [11:0] a;
        logic signed [11:0] f;
        logic signed [11:0] m;
        d = $signed({5'b0, p}) - $signed({{2{s[XY_W-1]}}, s});
        a = d[11] ? -d : d;
        f = (a > half) ? grid - a : a;
        m = f[11] ? -f : f;
        return m[MAG_W-1:0];
    endfunction

    logic              r_v1, r_v2, r_v3;
    logic [AW-1:0]     r_i1, r_i2, r_i3;
    logic [MAG_W-1:0]  r_mx, r_my;
    logic [DIST_W-1:0] r_sx, r_sy, r_sum;
    logic [DIST_W-1:0] w_mx, w_my;

    assign w_mx = DIST_W'(r_mx);
    assign w_my = DIST_W'(r_my);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage payloads: fold, square, sum
    always_ff @(posedge i_clk) begin
        r_i1  <= i_idx;
        r_mx  <= fold_mag(i_px, i_seed_x, GRID_X, HALF_X);
        r_my  <= fold_mag(i_py, i_seed_y, GRID_Y, HALF_Y);
        r_i2  <= r_i1;
        r_sx  <= w_mx * w_mx;
        r_sy  <= w_my * w_my;
        r_i3  <= r_i2;
        r_sum <= r_sx + r_sy;
    end

    assign o_valid = r_v3;
    assign o_idx   = r_i3;
    assign o_dist  = r_sum;
    assign o_busy  = r_v1 | r_v2 | r_v3;

endmodule

// ===== src/toroidal_nearest_seed_distance_unit.sv =====
// Top level of the wrapped nearest-seed distance unit: sequencer, seed RAM, minimum search.
// Depends on nsd_pkg, nsd_ram and nsd_dist.

// A write item stores one seed in the seed RAM. A query item scans seeds 0
// to n-1, with n the smaller of active_seeds and MAX_SEEDS, reading one seed
// per cycle from the single read port of the seed RAM. Its result passes in
// order through the n reads, the registered RAM read, the three distance
// stages, a check that the pipeline is empty and the load of the output
// register. Items are taken only while no query is in progress, and the next
// item is taken in the cycle after the result is loaded. A finished result
// waits in the output register, so a write may be taken while it is still
// pending; a second query stalls before its load until the pending result
// has gone. The result is the smallest wrapped squared distance, lowest
// index on ties; with n zero the result is 1000000 at index 0. Seeds never
// written read as arbitrary positions.
module toroidal_nearest_seed_distance_unit
    import nsd_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int MAX_SEEDS   = MAX_SEEDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [SIDX_W-1:0] i_seed_index,
    input  logic [XY_W-1:0]   i_seed_x,
    input  logic [XY_W-1:0]   i_seed_y,
    input  logic [PIX_W-1:0]  i_pixel_x,
    input  logic [PIX_W-1:0]  i_pixel_y,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_distance_sq,
    output logic [NIDX_W-1:0] o_nearest_index
);

    localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CW = $clog2(MAX_SEEDS + 1);
    localparam int RW = 2 * XY_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_active;
    logic [CW-1:0]     r_count, r_idx;
    logic [PIX_W-1:0]  r_px, r_py;
    logic [DIST_W-1:0] r_best;
    logic [NIDX_W-1:0] r_best_idx;
    logic              r_rd_valid;
    logic [AW-1:0]     r_rd_idx;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic [NIDX_W-1:0] r_out_idx;

    logic              w_in_xfer, w_out_xfer;
    logic              w_wr, w_query, w_rd_en, w_last, w_load;
    logic [31:0]       w_widx32, w_cidx32;
    logic [CW-1:0]     w_count;
    logic [RW-1:0]     w_rdata;
    logic              w_dv, w_dbusy;
    logic [AW-1:0]     w_didx;
    logic [DIST_W-1:0] w_ddist;

    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign w_out_xfer  = r_out_valid & ~i_out_stall;
    assign w_query     = w_in_xfer & (i_op == OP_QUERY);
    assign w_widx32    = 32'(i_seed_index);
    assign w_wr        = w_in_xfer & (i_op == OP_WRITE) & (w_widx32 < 32'(MAX_SEEDS));
    assign w_count     = (32'(r_active) > 32'(MAX_SEEDS)) ? CW'(MAX_SEEDS) : CW'(r_active);
    assign w_last      = (r_idx == r_count - CW'(1)) | (r_count == '0);
    assign w_cidx32    = 32'(w_didx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_query) n_state = S_SCAN;
            S_SCAN:  if (w_last) n_state = S_DRAIN;
            S_DRAIN: if (!r_rd_valid && !w_dbusy) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_rd_en    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCAN:  w_rd_en = (r_count != '0);
            S_DRAIN: ;
            S_DONE:  w_load = ~r_out_valid | ~i_out_stall;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RST;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query setup, read address counter and running minimum
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px     <= i_pixel_x;
            r_py     <= i_pixel_y;
            r_count  <= w_count;
            r_idx    <= '0;
            r_best   <= START_MIN;
            r_best_idx <= '0;
        end else begin
            if (w_rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
            // strictly nearer only, so the lowest index keeps a tie
            if (w_dv && (w_ddist < r_best)) begin
                r_best     <= w_ddist;
                r_best_idx <= w_cidx32[NIDX_W-1:0];
            end
        end
        r_rd_idx <= r_idx[AW-1:0];
        if (w_load) begin
            r_out_dist <= r_best;
            r_out_idx  <= r_best_idx;
        end
    end

    // seed RAM: writes happen only while idle, so reads of a query never overlap them
    nsd_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SEEDS),
        .AW    (AW)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_widx32[AW-1:0]),
        .i_wdata ({i_seed_x, i_seed_y}),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // distance pipeline
    nsd_dist #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .AW          (AW)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_valid),
        .i_idx    (r_rd_idx),
        .i_seed_x (w_rdata[RW-1:XY_W]),
        .i_seed_y (w_rdata[XY_W-1:0]),
        .i_px     (r_px),
        .i_py     (r_py),
        .o_valid  (w_dv),
        .o_idx    (w_didx),
        .o_dist   (w_ddist),
        .o_busy   (w_dbusy)
    );

    assign o_out_valid     = r_out_valid;
    assign o_distance_sq   = r_out_dist;
    assign o_nearest_index = r_out_idx;

endmodule
